/* rtl/tppd_pkg.sv */
// Shared types and constants for the timed press pattern detector.
// Used by tppd_core and by the top level; depends on nothing else.
package tppd_pkg;

  localparam int COUNT_WIDTH = 14;
  localparam int WIN_WIDTH   = 14;
  localparam int DEB_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > WIN_WIDTH) ? COUNT_WIDTH : WIN_WIDTH;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 16;

  typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_HAND_WINDOW    = 3'd0;
  localparam cfg_idx_t CFG_FOOT_WINDOW    = 3'd1;
  localparam cfg_idx_t CFG_MIN_PHASE      = 3'd2;
  localparam cfg_idx_t CFG_DEBOUNCE_TICKS = 3'd3;
  localparam cfg_idx_t CFG_COUNTER_TOP    = 3'd4;

  localparam logic [WIN_WIDTH-1:0] RESET_HAND_WINDOW    = 14'd8000;
  localparam logic [WIN_WIDTH-1:0] RESET_FOOT_WINDOW    = 14'd9000;
  localparam logic [WIN_WIDTH-1:0] RESET_MIN_PHASE      = 14'd1000;
  localparam logic [DEB_WIDTH-1:0] RESET_DEBOUNCE_TICKS = 16'd1562;
  localparam logic [WIN_WIDTH-1:0] RESET_COUNTER_TOP    = 14'd12500;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_IDLE      = 2'd0;
  localparam status_t STATUS_MEASURING = 2'd1;
  localparam status_t STATUS_ACCEPTED  = 2'd2;
  localparam status_t STATUS_REJECTED  = 2'd3;

  typedef struct packed {
    logic start_hand;
    logic start_foot;
    logic hand_level;
    logic foot_level;
  } in_beat_t;

  typedef struct packed {
    logic    elevation_on;
    logic    motors_stop;
    logic    home_request;
    status_t status;
  } out_beat_t;

  typedef struct packed {
    logic [WIN_WIDTH-1:0] hand_window;
    logic [WIN_WIDTH-1:0] foot_window;
    logic [WIN_WIDTH-1:0] min_phase;
    logic [DEB_WIDTH-1:0] debounce_ticks;
    logic [WIN_WIDTH-1:0] counter_top;
  } cfg_regs_t;

endpackage

/* rtl/tppd_core.sv */
// Pattern state machine of the timed press pattern detector: phase timing,
// debounce waits and the final verdict. Uses types and constants from tppd_pkg.
module tppd_core import tppd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_beat_t  beat,
  input  cfg_regs_t cfg,
  output out_beat_t result
);

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_HELD1 = 7'b0000010,
    PH_WAIT1 = 7'b0000100,
    PH_REL   = 7'b0001000,
    PH_WAIT2 = 7'b0010000,
    PH_HELD2 = 7'b0100000,
    PH_WAIT3 = 7'b1000000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] phase_count, phase_count_next;
  logic [DEB_WIDTH-1:0]   debounce_count, debounce_count_next;
  logic                   all_phases_ok, all_phases_ok_next;
  logic                   source_is_foot, source_is_foot_next;
  logic                   elevation_state, elevation_state_next;

  logic                   level;
  logic                   want;
  logic [CMP_WIDTH-1:0]   count_ext;
  logic [CMP_WIDTH-1:0]   window_ext;
  logic [CMP_WIDTH-1:0]   min_ext;
  logic [CMP_WIDTH-1:0]   top_ext;
  logic                   below_window;
  logic [DEB_WIDTH-1:0]   debounce_inc;
  logic                   motors;
  logic                   home;
  status_t                status;

  assign level      = source_is_foot ? beat.foot_level : beat.hand_level;
  assign count_ext  = CMP_WIDTH'(phase_count);
  assign window_ext = CMP_WIDTH'(source_is_foot ? cfg.foot_window : cfg.hand_window);
  assign min_ext    = CMP_WIDTH'(cfg.min_phase);
  assign top_ext    = CMP_WIDTH'(cfg.counter_top);
  assign below_window = count_ext < window_ext;
  assign want         = (phase != PH_REL);
  assign debounce_inc = debounce_count + DEB_WIDTH'(1);

  always_comb begin
    phase_next           = phase;
    phase_count_next     = phase_count;
    debounce_count_next  = debounce_count;
    all_phases_ok_next   = all_phases_ok;
    source_is_foot_next  = source_is_foot;
    elevation_state_next = elevation_state;
    motors = 1'b0;
    home   = 1'b0;
    status = STATUS_MEASURING;
    unique case (phase)
      PH_IDLE: begin
        status = STATUS_IDLE;
        if (beat.start_foot || beat.start_hand) begin
          source_is_foot_next  = beat.start_foot;
          elevation_state_next = 1'b0;
          motors               = 1'b1;
          status               = STATUS_MEASURING;
          phase_count_next     = '0;
          debounce_count_next  = '0;
          all_phases_ok_next   = 1'b1;
          phase_next           = PH_HELD1;
        end
      end
      PH_HELD1, PH_REL, PH_HELD2: begin
        if ((level == want) && below_window) begin
          if (count_ext == top_ext) begin
            phase_count_next = '0;
          end else begin
            phase_count_next = phase_count + COUNT_WIDTH'(1);
          end
        end else begin
          all_phases_ok_next  = all_phases_ok && (count_ext > min_ext) && below_window;
          debounce_count_next = '0;
          if (phase == PH_HELD1) begin
            phase_next = PH_WAIT1;
          end else if (phase == PH_REL) begin
            phase_next = PH_WAIT2;
          end else begin
            phase_next = PH_WAIT3;
          end
        end
      end
      PH_WAIT1, PH_WAIT2, PH_WAIT3: begin
        debounce_count_next = debounce_inc;
        if (debounce_inc >= cfg.debounce_ticks) begin
          debounce_count_next = '0;
          phase_count_next    = '0;
          if (phase == PH_WAIT3) begin
            if (all_phases_ok) begin
              home                 = 1'b1;
              elevation_state_next = 1'b1;
              status               = STATUS_ACCEPTED;
            end else begin
              status = STATUS_REJECTED;
            end
            phase_next = PH_IDLE;
          end else if (phase == PH_WAIT1) begin
            phase_next = PH_REL;
          end else begin
            phase_next = PH_HELD2;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        status     = STATUS_IDLE;
      end
    endcase
  end

  assign result.elevation_on = elevation_state_next;
  assign result.motors_stop  = motors;
  assign result.home_request = home;
  assign result.status       = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      phase_count     <= '0;
      debounce_count  <= '0;
      all_phases_ok   <= 1'b1;
      source_is_foot  <= 1'b0;
      elevation_state <= 1'b1;
    end else if (step) begin
      phase           <= phase_next;
      phase_count     <= phase_count_next;
      debounce_count  <= debounce_count_next;
      all_phases_ok   <= all_phases_ok_next;
      source_is_foot  <= source_is_foot_next;
      elevation_state <= elevation_state_next;
    end
  end

endmodule

/* rtl/timed_press_pattern_detector.sv */
// Top level of the timed press pattern detector: handshakes, configuration
// registers, input and result registers. Depends on tppd_pkg and tppd_core.
//
// Each input beat is one timer tick and yields exactly one result beat. A beat
// goes from the input register through the pattern state machine into the
// result register; it waits in the input register while the result register
// holds a result that is not taken. A new tick can be taken in every cycle as
// long as results are drained. The single state update per tick is one counter
// step and a few compares.
// Configuration writes are always taken (cfg_ready is high) and should only be
// issued while no tick is in flight.
module timed_press_pattern_detector import tppd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_beat_t                  in_beat,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_beat_t                 out_beat,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  cfg_idx_t                  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  cfg_regs_t cfg;
  logic      hold_valid;
  in_beat_t  hold_beat;
  logic      step;
  out_beat_t result;

  assign cfg_ready = 1'b1;
  assign step      = hold_valid && (!out_valid || !out_stall);
  assign in_stall  = hold_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hand_window    <= RESET_HAND_WINDOW;
      cfg.foot_window    <= RESET_FOOT_WINDOW;
      cfg.min_phase      <= RESET_MIN_PHASE;
      cfg.debounce_ticks <= RESET_DEBOUNCE_TICKS;
      cfg.counter_top    <= RESET_COUNTER_TOP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HAND_WINDOW:    cfg.hand_window    <= cfg_data[WIN_WIDTH-1:0];
        CFG_FOOT_WINDOW:    cfg.foot_window    <= cfg_data[WIN_WIDTH-1:0];
        CFG_MIN_PHASE:      cfg.min_phase      <= cfg_data[WIN_WIDTH-1:0];
        CFG_DEBOUNCE_TICKS: cfg.debounce_ticks <= cfg_data[DEB_WIDTH-1:0];
        CFG_COUNTER_TOP:    cfg.counter_top    <= cfg_data[WIN_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_beat <= in_beat;
    end
  end

  tppd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .beat   (hold_beat),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_beat <= result;
    end
  end

endmodule

/* sim/timed_press_pattern_detector_tb.sv */
// Self-checking testbench for timed_press_pattern_detector: drives timer ticks,
// predicts every result beat and compares it field by field with the block.
// Depends on tppd_pkg and the block's RTL.
`timescale 1ns / 1ps

module timed_press_pattern_detector_tb;
  import tppd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TICK_TARGET = 1650;

  typedef enum logic [2:0] {
    PAT_IDLE, PAT_HELD1, PAT_WAIT1, PAT_REL, PAT_WAIT2, PAT_HELD2, PAT_WAIT3
  } pat_phase_e;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  in_beat_t                  in_beat;
  logic                      out_valid;
  logic                      out_stall;
  out_beat_t                 out_beat;
  logic                      cfg_valid;
  logic                      cfg_ready;
  cfg_idx_t                  cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  timed_press_pattern_detector dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted detector state and register copies.
  logic [WIN_WIDTH-1:0] win_hand, win_foot, min_len, top_count;
  logic [DEB_WIDTH-1:0] settle_ticks, settle_cnt;
  logic [COUNT_WIDTH-1:0] run_len;
  pat_phase_e ph;
  logic good_so_far, use_foot, elev;

  out_beat_t predicted_outputs[$];
  out_beat_t want_beat;
  int mismatches = 0;
  int ticks_sent = 0;
  int cycle_count = 0;
  bit send_gaps_on = 1'b1;
  bit take_gaps_on = 1'b1;
  int hold_off_cycles = 0;

  function automatic void reset_model();
    win_hand = RESET_HAND_WINDOW;
    win_foot = RESET_FOOT_WINDOW;
    min_len = RESET_MIN_PHASE;
    settle_ticks = RESET_DEBOUNCE_TICKS;
    top_count = RESET_COUNTER_TOP;
    ph = PAT_IDLE;
    run_len = '0;
    settle_cnt = '0;
    good_so_far = 1'b1;
    use_foot = 1'b0;
    elev = 1'b1;
  endfunction

  function automatic out_beat_t step_detector(in_beat_t b);
    out_beat_t r;
    logic lvl;
    logic want;
    logic [WIN_WIDTH-1:0] lim;
    r = '0;
    r.status = STATUS_MEASURING;
    lvl = use_foot ? b.foot_level : b.hand_level;
    lim = use_foot ? win_foot : win_hand;
    case (ph)
      PAT_IDLE: begin
        r.status = STATUS_IDLE;
        if (b.start_foot || b.start_hand) begin
          use_foot = b.start_foot;
          elev = 1'b0;
          r.motors_stop = 1'b1;
          r.status = STATUS_MEASURING;
          run_len = '0;
          settle_cnt = '0;
          good_so_far = 1'b1;
          ph = PAT_HELD1;
        end
      end
      PAT_HELD1, PAT_REL, PAT_HELD2: begin
        want = (ph != PAT_REL);
        if (lvl == want && run_len < lim) begin
          if (run_len == top_count) run_len = '0;
          else run_len = run_len + 1'b1;
        end else begin
          good_so_far = good_so_far && run_len > min_len && run_len < lim;
          settle_cnt = '0;
          ph = pat_phase_e'(ph + 3'd1);
        end
      end
      PAT_WAIT1, PAT_WAIT2, PAT_WAIT3: begin
        settle_cnt = settle_cnt + 1'b1;
        if (settle_cnt >= settle_ticks) begin
          settle_cnt = '0;
          run_len = '0;
          if (ph == PAT_WAIT3) begin
            if (good_so_far) begin
              r.home_request = 1'b1;
              elev = 1'b1;
              r.status = STATUS_ACCEPTED;
            end else begin
              r.status = STATUS_REJECTED;
            end
            ph = PAT_IDLE;
          end else begin
            ph = pat_phase_e'(ph + 3'd1);
          end
        end
      end
      default: begin
        ph = PAT_IDLE;
        r.status = STATUS_IDLE;
      end
    endcase
    r.elevation_on = elev;
    return r;
  endfunction

  function automatic in_beat_t mk_beat(logic sh, logic sf, logic hl, logic fl);
    in_beat_t b;
    b.start_hand = sh;
    b.start_foot = sf;
    b.hand_level = hl;
    b.foot_level = fl;
    return b;
  endfunction

  task automatic send_tick(in_beat_t b);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_stall);
    predicted_outputs.push_back(step_detector(b));
    ticks_sent++;
  endtask

  task automatic drain_ticks();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_WIDTH-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HAND_WINDOW:    win_hand = val[WIN_WIDTH-1:0];
      CFG_FOOT_WINDOW:    win_foot = val[WIN_WIDTH-1:0];
      CFG_MIN_PHASE:      min_len = val[WIN_WIDTH-1:0];
      CFG_DEBOUNCE_TICKS: settle_ticks = val[DEB_WIDTH-1:0];
      CFG_COUNTER_TOP:    top_count = val[WIN_WIDTH-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One held, released, held sequence on the chosen switch with random
  // surroundings; noisy sequences flip the level now and then.
  task automatic press_pattern(bit foot, int n1, int n2, int n3, bit noisy);
    int seg [4];
    int wt;
    logic lv;
    in_beat_t b;
    wt = (settle_ticks == 0) ? 1 : int'(settle_ticks);
    seg = '{n1, n2 + wt + 1, n3 + wt + 1, wt + 2};
    b = in_beat_t'(4'($urandom));
    b.start_foot = foot;
    b.start_hand = foot ? 1'($urandom_range(0, 1)) : 1'b1;
    send_tick(b);
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < seg[k]; j++) begin
        lv = (k == 0 || k == 2);
        if (noisy && $urandom_range(0, 9) == 0) lv = !lv;
        b.hand_level = 1'($urandom_range(0, 1));
        b.foot_level = 1'($urandom_range(0, 1));
        if (foot) b.foot_level = lv;
        else b.hand_level = lv;
        b.start_hand = ($urandom_range(0, 15) == 0);
        b.start_foot = ($urandom_range(0, 15) == 0);
        send_tick(b);
      end
    end
  endtask

  function automatic logic [WIN_WIDTH-1:0] pick_window();
    if ($urandom_range(0, 7) == 0) return '0;
    return WIN_WIDTH'($urandom_range(4, 30));
  endfunction

  function automatic int pick_len(logic [WIN_WIDTH-1:0] lim);
    int lo;
    lo = int'(min_len) + 1;
    if (int'(lim) > lo && $urandom_range(0, 2) != 0) return $urandom_range(lo, int'(lim) - 1);
    return $urandom_range(0, int'(lim) + 3);
  endfunction

  task automatic test_reset_values();
    send_tick(mk_beat(1'b0, 1'b0, 1'b1, 1'b1));
    send_tick(mk_beat(1'b1, 1'b0, 1'b1, 1'b0));
    send_tick(mk_beat(1'b0, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic test_zero_window();
    drain_ticks();
    write_reg(CFG_HAND_WINDOW, '0);
    write_reg(CFG_FOOT_WINDOW, '0);
    write_reg(CFG_DEBOUNCE_TICKS, 16'd1);
    repeat (6) send_tick(mk_beat(1'b0, 1'b0, 1'b1, 1'b1));
  endtask

  task automatic test_short_accept();
    logic [8:0] hand_seq;
    drain_ticks();
    write_reg(CFG_HAND_WINDOW, 16'd2);
    write_reg(CFG_MIN_PHASE, '0);
    hand_seq = 9'b100011101;
    send_tick(mk_beat(1'b1, 1'b0, 1'b0, 1'b1));
    for (int i = 0; i < 9; i++) send_tick(mk_beat(1'b0, 1'b0, hand_seq[i], 1'($urandom)));
  endtask

  task automatic test_counter_wrap();
    drain_ticks();
    write_reg(CFG_FOOT_WINDOW, 16'hFFFF);
    write_reg(CFG_COUNTER_TOP, 16'd1);
    send_tick(mk_beat(1'b1, 1'b1, 1'b0, 1'b0));
    repeat (4) send_tick(mk_beat(1'b0, 1'b0, 1'b0, 1'b1));
    send_tick(mk_beat(1'b0, 1'b0, 1'b1, 1'b0));
  endtask

  task automatic test_long_settle();
    logic [6:0] foot_seq;
    drain_ticks();
    write_reg(CFG_DEBOUNCE_TICKS, 16'hFFFF);
    write_reg(CFG_MIN_PHASE, 16'h3FFF);
    write_reg(CFG_COUNTER_TOP, 16'h3FFF);
    repeat (3) send_tick(mk_beat(1'b1, 1'b0, 1'b1, 1'b1));
    drain_ticks();
    write_reg(CFG_DEBOUNCE_TICKS, '0);
    foot_seq = 7'b0111100;
    for (int i = 0; i < 7; i++) send_tick(mk_beat(1'b0, 1'b0, 1'($urandom), foot_seq[i]));
  endtask

  task automatic test_output_hold();
    drain_ticks();
    write_reg(CFG_HAND_WINDOW, 16'd8);
    write_reg(CFG_MIN_PHASE, 16'd2);
    write_reg(CFG_DEBOUNCE_TICKS, 16'd3);
    send_gaps_on = 1'b0;
    take_gaps_on = 1'b0;
    hold_off_cycles = 150;
    press_pattern(1'b0, 4, 4, 4, 1'b0);
    repeat (20) send_tick(in_beat_t'(4'($urandom)));
  endtask

  task automatic test_random_patterns();
    logic [WIN_WIDTH-1:0] lim;
    int r;
    bit foot;
    while (ticks_sent < TICK_TARGET) begin
      drain_ticks();
      write_reg(CFG_HAND_WINDOW, {2'($urandom_range(0, 3)), pick_window()});
      write_reg(CFG_FOOT_WINDOW, {2'($urandom_range(0, 3)), pick_window()});
      write_reg(CFG_MIN_PHASE, {2'($urandom_range(0, 3)), WIN_WIDTH'($urandom_range(0, 12))});
      write_reg(CFG_DEBOUNCE_TICKS, DEB_WIDTH'($urandom_range(0, 4)));
      write_reg(CFG_COUNTER_TOP, {2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0) ?
                WIN_WIDTH'($urandom_range(1, 25)) : WIN_WIDTH'(16383)});
      send_gaps_on = ($urandom_range(0, 3) != 0);
      take_gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 5)) begin
        r = $urandom_range(0, 9);
        foot = 1'($urandom_range(0, 1));
        lim = foot ? win_foot : win_hand;
        if (r == 0) begin
          repeat ($urandom_range(5, 20)) send_tick(in_beat_t'(4'($urandom)));
        end else begin
          press_pattern(foot, pick_len(lim), pick_len(lim), pick_len(lim), r < 3);
        end
      end
    end
  endtask

  // Result side: random stalls per beat, plus one long hold when requested.
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      gap = take_gaps_on ? $urandom_range(0, 8) : 0;
      if (hold_off_cycles > 0) begin
        gap = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic flag_field(string name, int want, int got);
    if (mismatches < 10)
      $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (predicted_outputs.size() == 0) begin
        if (mismatches < 10) $display("result beat with no prediction: %p", out_beat);
        mismatches++;
      end else begin
        want_beat = predicted_outputs.pop_front();
        if (out_beat.elevation_on !== want_beat.elevation_on)
          flag_field("elevation_on", want_beat.elevation_on, out_beat.elevation_on);
        if (out_beat.motors_stop !== want_beat.motors_stop)
          flag_field("motors_stop", want_beat.motors_stop, out_beat.motors_stop);
        if (out_beat.home_request !== want_beat.home_request)
          flag_field("home_request", want_beat.home_request, out_beat.home_request);
        if (out_beat.status !== want_beat.status)
          flag_field("status", want_beat.status, out_beat.status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed_press_pattern_detector_tb failed");
      $finish;
    end
  end

  initial begin
    reset_model();
    rst = 1'b1;
    in_valid = 1'b0;
    in_beat = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HAND_WINDOW;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_zero_window();
    test_short_accept();
    test_counter_wrap();
    test_long_settle();
    test_output_hold();
    test_random_patterns();
    drain_ticks();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("timed_press_pattern_detector_tb passed");
    end else begin
      $display("timed_press_pattern_detector_tb failed");
    end
    $finish;
  end

endmodule

/* timed_press_pattern_detector.f */
rtl/tppd_pkg.sv
rtl/tppd_core.sv
rtl/timed_press_pattern_detector.sv
sim/timed_press_pattern_detector_tb.sv
